@@ rtl/fwdaf_pkg.sv @@
// shared types and constants for the decimal ascii formatter
`timescale 1ns / 1ps
package fwdaf_pkg;

  localparam int unsigned VAL_W       = 14;
  localparam int unsigned DIGITS      = 4;
  localparam int unsigned BCD_W       = 4 * DIGITS;
  localparam int unsigned SLOTS       = 8;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned PROD_W      = VAL_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 19;

  // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every x below 2**14
  localparam logic [RECIP_W-1:0] RECIP     = 16'd52429;
  localparam logic [VAL_W-1:0]   MAX_SHOWN = 14'd9999;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_M     = 8'h6D;

  localparam logic MODE_PLAIN    = 1'b0;
  localparam logic MODE_DISTANCE = 1'b1;

  // value travelling down the digit chain
  typedef struct packed {
    logic             over;
    logic [VAL_W-1:0] rest;
    logic [BCD_W-1:0] bcd;
  } dig_t;

  // one character position of the output row
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    logic       last;
  } slot_t;

endpackage

@@ rtl/fwdaf_digit_cell.sv @@
// digit cell: peels one decimal digit off the value and hands the rest on
`timescale 1ns / 1ps
module fwdaf_digit_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  fwdaf_pkg::dig_t in_data_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output fwdaf_pkg::dig_t out_data_o,
  input  logic            out_ready_i
);
  import fwdaf_pkg::*;

  logic              valid_q, valid_d;
  dig_t              data_q, data_d;
  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  quot;
  logic [VAL_W-1:0]  mul10;
  logic [3:0]        rem;

  assign in_ready_o = !valid_q || out_ready_i;

  // divide by ten through the reciprocal, remainder fits in four bits
  assign prod  = PROD_W'(in_data_i.rest) * PROD_W'(RECIP);
  assign quot  = VAL_W'(prod >> RECIP_SHIFT);
  assign mul10 = VAL_W'({quot, 3'b000}) + VAL_W'({quot, 1'b0});
  assign rem   = in_data_i.rest[3:0] - mul10[3:0];

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        data_d.over = in_data_i.over;
        data_d.rest = quot;
        data_d.bcd  = {rem, in_data_i.bcd[BCD_W-1:4]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/fwdaf_char_cell.sv @@
// character cell: loads its text position or takes its neighbour's
`timescale 1ns / 1ps
module fwdaf_char_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  fwdaf_pkg::slot_t load_slot_i,
  input  logic             shift_i,
  input  fwdaf_pkg::slot_t next_slot_i,
  output fwdaf_pkg::slot_t slot_o
);
  import fwdaf_pkg::*;

  slot_t slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (load_i) begin
      slot_d = load_slot_i;
    end else if (shift_i) begin
      slot_d = next_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

@@ rtl/fixed_width_decimal_ascii_formatter_top.sv @@
// top level of the decimal ascii formatter
`timescale 1ns / 1ps
// Each accepted value is turned into text and sent out one ASCII character
// per cycle while out_stall_i is low, last_char_o marking the final one:
// five characters in plain mode, eight in distance mode, so once the output
// flows freely new values are taken at the pace of the character row. A value
// passes a chain of four digit cells, each a register stage, before its text is
// loaded, and the next value is converted while the current text drains.
// Values above 9999 show stars. Write format_mode only while idle.
module fixed_width_decimal_ascii_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        format_mode_we_i,
  input  logic        format_mode_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_code_o,
  output logic        last_char_o
);
  import fwdaf_pkg::*;

  logic              format_mode_q;
  logic              d_valid [DIGITS+1];
  dig_t              d_data  [DIGITS+1];
  logic              d_ready [DIGITS+1];
  slot_t             slot    [SLOTS];
  slot_t             text    [SLOTS];
  slot_t             slot_next [SLOTS];
  logic [7:0]        asc     [DIGITS];
  logic              take;
  logic              load;
  logic              blank3, blank2, blank1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_mode_q <= MODE_PLAIN;
    end else if (format_mode_we_i) begin
      format_mode_q <= format_mode_wdata_i;
    end
  end

  // request enters the digit chain straight from the port
  assign d_valid[0]     = in_valid_i;
  assign d_data[0].over = (value_i[31:VAL_W] != '0) || (value_i[VAL_W-1:0] > MAX_SHOWN);
  assign d_data[0].rest = value_i[VAL_W-1:0];
  assign d_data[0].bcd  = '0;
  assign in_stall_o     = !d_ready[0];

  for (genvar k = 0; k < DIGITS; k++) begin : g_digit
    fwdaf_digit_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (d_valid[k]),
      .in_data_i   (d_data[k]),
      .in_ready_o  (d_ready[k]),
      .out_valid_o (d_valid[k+1]),
      .out_data_o  (d_data[k+1]),
      .out_ready_i (d_ready[k+1])
    );
  end

  // the row loads as its last character leaves, so texts follow without a gap
  assign take           = slot[0].valid && !out_stall_i;
  assign load           = d_valid[DIGITS] && (!slot[0].valid || (take && slot[0].last));
  assign d_ready[DIGITS] = load;

  // thousands digit sits in the top nibble
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (d_data[DIGITS].over) begin
        asc[i] = CH_STAR;
      end else begin
        asc[i] = CH_ZERO | {4'h0, d_data[DIGITS].bcd[BCD_W-1-4*i -: 4]};
      end
    end
  end

  // leading zero blanking for plain mode, units never blanked
  assign blank3 = !d_data[DIGITS].over && (d_data[DIGITS].bcd[15:12] == 4'd0);
  assign blank2 = blank3 && (d_data[DIGITS].bcd[11:8] == 4'd0);
  assign blank1 = blank2 && (d_data[DIGITS].bcd[7:4] == 4'd0);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      text[i] = '0;
    end
    if (format_mode_q == MODE_PLAIN) begin
      text[0] = '{valid: 1'b1, code: blank3 ? CH_SPACE : asc[0], last: 1'b0};
      text[1] = '{valid: 1'b1, code: blank2 ? CH_SPACE : asc[1], last: 1'b0};
      text[2] = '{valid: 1'b1, code: blank1 ? CH_SPACE : asc[2], last: 1'b0};
      text[3] = '{valid: 1'b1, code: asc[3], last: 1'b0};
      text[4] = '{valid: 1'b1, code: CH_SPACE, last: 1'b1};
    end else begin
      text[0] = '{valid: 1'b1, code: asc[0], last: 1'b0};
      text[1] = '{valid: 1'b1, code: CH_POINT, last: 1'b0};
      text[2] = '{valid: 1'b1, code: asc[1], last: 1'b0};
      text[3] = '{valid: 1'b1, code: asc[2], last: 1'b0};
      text[4] = '{valid: 1'b1, code: asc[3], last: 1'b0};
      text[5] = '{valid: 1'b1, code: CH_SPACE, last: 1'b0};
      text[6] = '{valid: 1'b1, code: CH_C, last: 1'b0};
      text[7] = '{valid: 1'b1, code: CH_M, last: 1'b1};
    end
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_char
    if (k == SLOTS - 1) begin : g_end
      assign slot_next[k] = '0;
    end else begin : g_mid
      assign slot_next[k] = slot[k+1];
    end

    fwdaf_char_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .load_slot_i (text[k]),
      .shift_i     (take),
      .next_slot_i (slot_next[k]),
      .slot_o      (slot[k])
    );
  end

  assign out_valid_o = slot[0].valid;
  assign char_code_o = slot[0].code;
  assign last_char_o = slot[0].last;

endmodule
